@@ hdl/grid_mesh_tessellator_top_defines.svh @@
// Assertion macros for the grid mesh tessellator
`ifndef GRID_MESH_TESSELLATOR_TOP_DEFINES_SVH
`define GRID_MESH_TESSELLATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid mesh tessellator check failed");

// next-cycle implication, disabled in reset
`define GMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid mesh tessellator check failed");

`endif

@@ hdl/gmt_pkg.sv @@
// Shared types and constants of the grid mesh tessellator
`default_nettype none

package gmt_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int DATA_W     = 16;
    localparam int POINT_W    = 9;
    localparam int HALF_W     = 15;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_POINTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd3;

    localparam logic [DATA_W-1:0] TEX_OFFSET = DATA_W'(1 << (FRAC_BITS - 1));

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic load;
    } gmt_cmd_t;

    typedef struct packed {
        logic vertex;
        logic out_free;
    } gmt_stat_t;

endpackage

`default_nettype wire

@@ hdl/gmt_in_if.sv @@
// Input channel interface of the grid mesh tessellator
`default_nettype none

interface gmt_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ hdl/gmt_out_if.sv @@
// Result channel interface of the grid mesh tessellator
`default_nettype none

interface gmt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [gmt_pkg::DATA_W-1:0] pos_x;
    logic signed [gmt_pkg::DATA_W-1:0] pos_y;
    logic signed [gmt_pkg::DATA_W-1:0] tex_u;
    logic signed [gmt_pkg::DATA_W-1:0] tex_v;
    logic [gmt_pkg::DATA_W-1:0]   corner_a;
    logic [gmt_pkg::DATA_W-1:0]   corner_b;
    logic [gmt_pkg::DATA_W-1:0]   corner_c;
    logic                         last;

    modport source (output valid, output kind, output pos_x, output pos_y, output tex_u,
                    output tex_v, output corner_a, output corner_b, output corner_c,
                    output last, input ready);
    modport sink (input valid, input kind, input pos_x, input pos_y, input tex_u,
                  input tex_v, input corner_a, input corner_b, input corner_c,
                  input last, output ready);
endinterface

`default_nettype wire

@@ hdl/grid_mesh_tessellator_top.sv @@
// Top level of the grid mesh tessellator
// Streams a regular grid mesh, one result per accepted transaction on trig: first every
// vertex in row-major order, then two triangles per cell, the final one flagged by last,
// after which the sequence wraps to vertex zero; restart set in a transaction begins anew.
// A vertex passes through accept, a step that forms 2*half*index, the restoring dividers for x
// and y (one quotient bit per cycle) and a load that waits until the result register is free.
// A triangle skips the dividers. The result register lets the next transaction be accepted
// while a result still waits on res. Writing cols_points or rows_points restarts the mesh.
`default_nettype none
`include "grid_mesh_tessellator_top_defines.svh"

module grid_mesh_tessellator_top #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gmt_in_if.sink                              trig,
    gmt_out_if.source                           res,
    input  wire logic                           cfg_we,
    input  wire logic [gmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gmt_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    gmt_pkg::gmt_cmd_t  cmd;
    gmt_pkg::gmt_stat_t stat;
    logic               in_ready;

    gmt_ctrl #(.DIV_STEPS(gmt_pkg::DATA_W + CW)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (trig.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gmt_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .restart   (trig.restart),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .kind      (res.kind),
        .pos_x     (res.pos_x),
        .pos_y     (res.pos_y),
        .tex_u     (res.tex_u),
        .tex_v     (res.tex_v),
        .corner_a  (res.corner_a),
        .corner_b  (res.corner_b),
        .corner_c  (res.corner_c),
        .last      (res.last)
    );

    assign trig.ready = in_ready;

    `GMT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, trig.valid && trig.ready, !trig.ready)
    `GMT_ASSERT_NOW(a_last_on_triangle, clk, rst_n, res.valid && res.last, res.kind)
    `GMT_ASSERT_NOW(a_vertex_no_corners, clk, rst_n, res.valid && !res.kind, res.corner_a == 16'd0 && res.corner_b == 16'd0 && res.corner_c == 16'd0)
    `GMT_ASSERT_NOW(a_triangle_no_pos, clk, rst_n, res.valid && res.kind, res.pos_x == 16'sd0 && res.pos_y == 16'sd0 && res.tex_u == 16'sd0)

endmodule

`default_nettype wire

@@ hdl/gmt_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle while step is high
`default_nettype none

module gmt_div #(
    parameter int CW = 8,
    parameter int NW = 24
) (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic                          step,
    input  wire logic [NW-1:0]                 num,
    input  wire logic [CW-1:0]                 den,
    output      logic [gmt_pkg::DATA_W-1:0]    quot
);

    logic [NW-1:0] work_reg, work_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] den_reg, den_next;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial     = {rem_reg, work_reg[NW-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (load)
        begin
            work_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (step)
        begin
            work_next = {work_reg[NW-2:0], ge};
            rem_next  = ge ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quot = work_reg[gmt_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

@@ hdl/gmt_ctrl.sv @@
// Controller state machine of the grid mesh tessellator
`default_nettype none

module gmt_ctrl #(
    parameter int DIV_STEPS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire gmt_pkg::gmt_stat_t stat,
    output      gmt_pkg::gmt_cmd_t  cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = stat.vertex ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gmt_dp.sv @@
// Datapath of the grid mesh tessellator: registers, sequence state, dividers, result register
`default_nettype none

module gmt_dp #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire gmt_pkg::gmt_cmd_t                  cmd,
    output      gmt_pkg::gmt_stat_t                 stat,
    input  wire logic                               restart,
    input  wire logic                               cfg_we,
    input  wire logic [gmt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gmt_pkg::CFG_W-1:0]          cfg_data,
    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      logic                               kind,
    output      logic signed [gmt_pkg::DATA_W-1:0]  pos_x,
    output      logic signed [gmt_pkg::DATA_W-1:0]  pos_y,
    output      logic signed [gmt_pkg::DATA_W-1:0]  tex_u,
    output      logic signed [gmt_pkg::DATA_W-1:0]  tex_v,
    output      logic [gmt_pkg::DATA_W-1:0]         corner_a,
    output      logic [gmt_pkg::DATA_W-1:0]         corner_b,
    output      logic [gmt_pkg::DATA_W-1:0]         corner_c,
    output      logic                               last
);

    localparam int CW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = gmt_pkg::DATA_W + CW;
    localparam int PW = gmt_pkg::POINT_W;
    localparam int DW = gmt_pkg::DATA_W;

    function automatic logic [PW-1:0] eff_points(input logic [PW-1:0] n);
        logic [PW-1:0] r;
        r = n;
        if (n < PW'(2))
        begin
            r = PW'(2);
        end
        else if (n > PW'(MAX_POINTS))
        begin
            r = PW'(MAX_POINTS);
        end
        return r;
    endfunction

    logic [PW-1:0]               cols_reg, rows_reg;
    logic [gmt_pkg::HALF_W-1:0]  hw_reg, hh_reg;
    logic                        phase_reg, second_reg;
    logic [CW-1:0]               col_reg, row_reg;
    logic [DW-1:0]               base_reg;
    logic                        out_valid_reg;

    logic [PW-1:0]  nc, nr, nc_m1, nr_m1;
    logic           last_col, last_row, end_row, end_rows, end_all;
    logic [NW-1:0]  prod_x, prod_y;
    logic [DW-1:0]  qx, qy;
    logic signed [DW:0]   px_full, py_full;
    logic signed [DW-1:0] px, py, hx, hy;
    logic [DW-1:0]  nc16, ca, cb, cc;
    logic           seq_clear;

    always_comb
    begin
        nc       = eff_points(cols_reg);
        nr       = eff_points(rows_reg);
        nc_m1    = nc - PW'(1);
        nr_m1    = nr - PW'(1);
        last_col = (10'(col_reg) + 10'd1) >= 10'(nc);
        last_row = (10'(row_reg) + 10'd1) >= 10'(nr);
        end_row  = (10'(col_reg) + 10'd2) >= 10'(nc);
        end_rows = (10'(row_reg) + 10'd2) >= 10'(nr);
        end_all  = end_row && end_rows && second_reg;
        prod_x   = NW'({hw_reg, 1'b0}) * NW'(col_reg);
        prod_y   = NW'({hh_reg, 1'b0}) * NW'(row_reg);
        px_full  = $signed({1'b0, qx}) - $signed({2'b00, hw_reg});
        py_full  = $signed({1'b0, qy}) - $signed({2'b00, hh_reg});
        px       = px_full[DW-1:0];
        py       = py_full[DW-1:0];
        hx       = px >>> 1;
        hy       = py >>> 1;
        nc16     = DW'(nc);
        if (!second_reg)
        begin
            ca = base_reg;
            cb = base_reg + DW'(1);
            cc = base_reg + nc16;
        end
        else
        begin
            ca = base_reg + nc16;
            cb = base_reg + DW'(1);
            cc = base_reg + nc16 + DW'(1);
        end
        seq_clear = (cmd.accept && restart)
                 || (cfg_we && (cfg_index == gmt_pkg::CFG_COLS_POINTS
                                || cfg_index == gmt_pkg::CFG_ROWS_POINTS));
    end

    gmt_div #(.CW(CW), .NW(NW)) u_div_x (
        .clk  (clk),
        .load (cmd.mul),
        .step (cmd.div_step),
        .num  (prod_x),
        .den  (nc_m1[CW-1:0]),
        .quot (qx)
    );

    gmt_div #(.CW(CW), .NW(NW)) u_div_y (
        .clk  (clk),
        .load (cmd.mul),
        .step (cmd.div_step),
        .num  (prod_y),
        .den  (nr_m1[CW-1:0]),
        .quot (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= PW'(2);
            rows_reg      <= PW'(2);
            hw_reg        <= gmt_pkg::HALF_W'(4096);
            hh_reg        <= gmt_pkg::HALF_W'(4096);
            phase_reg     <= gmt_pkg::KIND_VERTEX;
            second_reg    <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gmt_pkg::CFG_COLS_POINTS: cols_reg <= cfg_data[PW-1:0];
                    gmt_pkg::CFG_ROWS_POINTS: rows_reg <= cfg_data[PW-1:0];
                    gmt_pkg::CFG_HALF_WIDTH:  hw_reg   <= cfg_data;
                    gmt_pkg::CFG_HALF_HEIGHT: hh_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (seq_clear)
            begin
                phase_reg  <= gmt_pkg::KIND_VERTEX;
                second_reg <= 1'b0;
                col_reg    <= '0;
                row_reg    <= '0;
                base_reg   <= '0;
            end
            else if (cmd.load)
            begin
                if (phase_reg == gmt_pkg::KIND_VERTEX)
                begin
                    if (last_col)
                    begin
                        col_reg <= '0;
                        if (last_row)
                        begin
                            phase_reg  <= gmt_pkg::KIND_TRIANGLE;
                            row_reg    <= '0;
                            second_reg <= 1'b0;
                            base_reg   <= '0;
                        end
                        else
                        begin
                            row_reg  <= row_reg + CW'(1);
                            base_reg <= base_reg + DW'(1);
                        end
                    end
                    else
                    begin
                        col_reg  <= col_reg + CW'(1);
                        base_reg <= base_reg + DW'(1);
                    end
                end
                else if (!second_reg)
                begin
                    second_reg <= 1'b1;
                end
                else if (end_all)
                begin
                    phase_reg  <= gmt_pkg::KIND_VERTEX;
                    second_reg <= 1'b0;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    base_reg   <= '0;
                end
                else
                begin
                    second_reg <= 1'b0;
                    if (end_row)
                    begin
                        col_reg  <= '0;
                        row_reg  <= row_reg + CW'(1);
                        base_reg <= base_reg + DW'(2);
                    end
                    else
                    begin
                        col_reg  <= col_reg + CW'(1);
                        base_reg <= base_reg + DW'(1);
                    end
                end
            end

            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind <= phase_reg;
            if (phase_reg == gmt_pkg::KIND_VERTEX)
            begin
                pos_x    <= px;
                pos_y    <= py;
                tex_u    <= hx + gmt_pkg::TEX_OFFSET;
                tex_v    <= hy + gmt_pkg::TEX_OFFSET;
                corner_a <= '0;
                corner_b <= '0;
                corner_c <= '0;
                last     <= 1'b0;
            end
            else
            begin
                pos_x    <= '0;
                pos_y    <= '0;
                tex_u    <= '0;
                tex_v    <= '0;
                corner_a <= ca;
                corner_b <= cb;
                corner_c <= cc;
                last     <= end_all;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign stat      = '{vertex:   (phase_reg == gmt_pkg::KIND_VERTEX),
                         out_free: (!out_valid_reg || out_ready)};

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the grid mesh tessellator: random streams checked against a mesh predictor
`timescale 1ns / 100ps

localparam int GRID_MAX_POINTS = 256;
localparam int QUIET_LIMIT     = 4000;
localparam int DATA_W          = gmt_pkg::DATA_W;
localparam int POINT_W         = gmt_pkg::POINT_W;
localparam int HALF_W          = gmt_pkg::HALF_W;
localparam int CFG_IDX_W       = gmt_pkg::CFG_IDX_W;
localparam int CFG_W           = gmt_pkg::CFG_W;

typedef struct {
    logic                     kind;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] tex_u;
    logic signed [DATA_W-1:0] tex_v;
    logic [DATA_W-1:0]        corner_a;
    logic [DATA_W-1:0]        corner_b;
    logic [DATA_W-1:0]        corner_c;
    logic                     last;
} mesh_elem_t;

class mesh_scoreboard_t;
    typedef enum bit {SWEEP_VERTS, SWEEP_TRIS} mesh_sweep_t;

    bit [POINT_W-1:0] cols_raw;
    bit [POINT_W-1:0] rows_raw;
    bit [HALF_W-1:0]  half_x;
    bit [HALF_W-1:0]  half_y;
    mesh_sweep_t      sweep;
    bit [7:0]         row_i;
    bit [7:0]         col_i;
    bit               upper_tri;
    bit [15:0]        base;
    mesh_elem_t       pending_elems[$];
    int               errors;

    function new();
        cols_raw = 2;
        rows_raw = 2;
        half_x   = 4096;
        half_y   = 4096;
        errors   = 0;
        rewind();
    endfunction

    function void rewind();
        sweep     = SWEEP_VERTS;
        row_i     = 0;
        col_i     = 0;
        upper_tri = 1'b0;
        base      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            gmt_pkg::CFG_COLS_POINTS:
            begin
                cols_raw = data[POINT_W-1:0];
                rewind();
            end
            gmt_pkg::CFG_ROWS_POINTS:
            begin
                rows_raw = data[POINT_W-1:0];
                rewind();
            end
            gmt_pkg::CFG_HALF_WIDTH:  half_x = data[HALF_W-1:0];
            gmt_pkg::CFG_HALF_HEIGHT: half_y = data[HALF_W-1:0];
            default:;
        endcase
    endfunction

    function int point_count(bit [POINT_W-1:0] raw);
        if (raw < 2) return 2;
        if (raw > GRID_MAX_POINTS) return GRID_MAX_POINTS;
        return int'(raw);
    endfunction

    function int mesh_steps();
        int nc;
        int nr;
        nc = point_count(cols_raw);
        nr = point_count(rows_raw);
        return nc * nr + 2 * (nc - 1) * (nr - 1);
    endfunction

    function int axis_pos(int half, int k, int n);
        longint q;
        q = (2 * longint'(half) * longint'(k)) / longint'(n - 1);
        return int'(q) - half;
    endfunction

    function logic [DATA_W-1:0] tex_of(int p);
        return DATA_W'((p >>> 1) + int'(gmt_pkg::TEX_OFFSET));
    endfunction

    function void note_step(bit restart);
        int         nc;
        int         nr;
        int         x;
        int         y;
        int         a;
        bit         end_row;
        bit         end_all;
        mesh_elem_t e;
        nc = point_count(cols_raw);
        nr = point_count(rows_raw);
        if (restart) rewind();
        e = '{default: '0};
        if (sweep == SWEEP_VERTS)
        begin
            x       = axis_pos(half_x, col_i, nc);
            y       = axis_pos(half_y, row_i, nr);
            e.kind  = gmt_pkg::KIND_VERTEX;
            e.pos_x = DATA_W'(x);
            e.pos_y = DATA_W'(y);
            e.tex_u = tex_of(x);
            e.tex_v = tex_of(y);
            if (int'(col_i) + 1 >= nc)
            begin
                col_i = 0;
                if (int'(row_i) + 1 >= nr)
                begin
                    sweep     = SWEEP_TRIS;
                    row_i     = 0;
                    upper_tri = 1'b0;
                    base      = 0;
                end
                else
                begin
                    row_i++;
                    base++;
                end
            end
            else
            begin
                col_i++;
                base++;
            end
        end
        else
        begin
            a       = int'(base);
            end_row = (int'(col_i) + 2 >= nc);
            end_all = end_row && (int'(row_i) + 2 >= nr) && upper_tri;
            e.kind  = gmt_pkg::KIND_TRIANGLE;
            if (!upper_tri)
            begin
                e.corner_a = DATA_W'(a);
                e.corner_b = DATA_W'(a + 1);
                e.corner_c = DATA_W'(a + nc);
            end
            else
            begin
                e.corner_a = DATA_W'(a + nc);
                e.corner_b = DATA_W'(a + 1);
                e.corner_c = DATA_W'(a + nc + 1);
            end
            e.last = end_all;
            if (!upper_tri)
                upper_tri = 1'b1;
            else if (end_all)
                rewind();
            else
            begin
                upper_tri = 1'b0;
                if (end_row)
                begin
                    col_i = 0;
                    row_i++;
                    base += 2;
                end
                else
                begin
                    col_i++;
                    base++;
                end
            end
        end
        pending_elems.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 100) $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function void check_emit(mesh_elem_t got);
        mesh_elem_t want;
        if (pending_elems.size() == 0)
        begin
            errors++;
            if (errors <= 100) $error("result with no expected transaction");
            return;
        end
        want = pending_elems.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("tex_u", want.tex_u, got.tex_u);
        compare_field("tex_v", want.tex_v, got.tex_v);
        compare_field("corner_a", want.corner_a, got.corner_a);
        compare_field("corner_b", want.corner_b, got.corner_b);
        compare_field("corner_c", want.corner_c, got.corner_c);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module tb;
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   send_idle_pct;
    int                   sink_stall_pct;
    int                   quiet_cycles = 0;
    mesh_scoreboard_t     sb;

    gmt_in_if  trig ();
    gmt_out_if res ();

    grid_mesh_tessellator_top #(.MAX_POINTS(GRID_MAX_POINTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .trig      (trig),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, CFG_W'(value));
    endtask

    task automatic push_step(input bit restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            trig.valid <= 1'b0;
            @(posedge clk);
        end
        trig.valid   <= 1'b1;
        trig.restart <= restart;
        @(posedge clk);
        while (!trig.ready) @(posedge clk);
        sb.note_step(restart);
    endtask

    // hold the sender until every expected result has come back
    task automatic drain();
        trig.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_elems.size() != 0) @(posedge clk);
    endtask

    function automatic int pick_extent();
        case ($urandom_range(5))
            0: return 1;
            1: return 32767;
            2: return 0;
            default: return $urandom_range(32767);
        endcase
    endfunction

    task automatic random_block(output int sent);
        int grid_sel;
        int steps;
        int split;
        int i;
        drain();
        grid_sel = $urandom_range(9);
        if (grid_sel < 7)
        begin
            set_reg(gmt_pkg::CFG_COLS_POINTS, $urandom_range(2, 5));
            set_reg(gmt_pkg::CFG_ROWS_POINTS, $urandom_range(2, 5));
        end
        else if (grid_sel < 9)
        begin
            set_reg(gmt_pkg::CFG_COLS_POINTS, $urandom_range(32767));
            set_reg(gmt_pkg::CFG_ROWS_POINTS, $urandom_range(32767));
        end
        if ($urandom_range(1)) set_reg(gmt_pkg::CFG_HALF_WIDTH, pick_extent());
        if ($urandom_range(1)) set_reg(gmt_pkg::CFG_HALF_HEIGHT, pick_extent());
        steps = sb.mesh_steps() * $urandom_range(1, 2) + $urandom_range(0, 4);
        if (steps > 160) steps = $urandom_range(20, 80);
        split = ($urandom_range(3) == 0) ? steps / 2 : -1;
        for (i = 0; i < steps; i++)
        begin
            if (i == split) drain();
            push_step($urandom_range(99) < 2);
        end
        sent = steps;
    endtask

    always @(posedge clk)
    begin : watch_results
        mesh_elem_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.kind     = res.kind;
            got.pos_x    = res.pos_x;
            got.pos_y    = res.pos_y;
            got.tex_u    = res.tex_u;
            got.tex_v    = res.tex_v;
            got.corner_a = res.corner_a;
            got.corner_b = res.corner_b;
            got.corner_c = res.corner_c;
            got.last     = res.last;
            sb.check_emit(got);
        end
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((trig.valid && trig.ready) || (res.valid && res.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int phase_no;
        int phase_items;
        int sent;
        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        trig.valid     = 1'b0;
        trig.restart   = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default 2x2 mesh, restart partway, then run through last and wrap
        push_step(1'b0);
        push_step(1'b0);
        push_step(1'b1);
        repeat (6) push_step(1'b0);
        drain();
        set_reg(gmt_pkg::CFG_COLS_POINTS, 1);
        set_reg(gmt_pkg::CFG_ROWS_POINTS, 0);
        set_reg(gmt_pkg::CFG_HALF_WIDTH, 32767);
        set_reg(gmt_pkg::CFG_HALF_HEIGHT, 0);
        push_step(1'b0);
        push_step(1'b0);
        drain();
        // change extents mid-mesh without a restart
        set_reg(gmt_pkg::CFG_HALF_HEIGHT, 32767);
        set_reg(gmt_pkg::CFG_HALF_WIDTH, 1);
        repeat (4) push_step(1'b0);
        drain();
        set_reg(gmt_pkg::CFG_COLS_POINTS, 300);
        set_reg(gmt_pkg::CFG_ROWS_POINTS, 2);
        push_step(1'b0);
        push_step(1'b0);
        push_step(1'b1);
        drain();
        set_reg(gmt_pkg::CFG_ROWS_POINTS, 257);
        set_reg(gmt_pkg::CFG_COLS_POINTS, 3);
        repeat (4) push_step(1'b0);

        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            drain();
            case (phase_no)
                0:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    sink_stall_pct = 33;
                end
            endcase
            phase_items = 0;
            while (phase_items < 335)
            begin
                random_block(sent);
                phase_items += sent;
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.pending_elems.size() != 0)
            $error("%0d expected results never arrived", sb.pending_elems.size());
        if (sb.errors == 0 && sb.pending_elems.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
